@@ design/mrdb_pkg.sv @@
package mrdb_pkg;

  // Frame geometry
  localparam int ROW_SAMPLES = 64;
  localparam int MAX_ROWS    = 64;
  localparam int ROW_BYTES   = 2 * ROW_SAMPLES;

  // Field widths
  localparam int BYTE_W      = 8;
  localparam int SAMPLE_W    = 16;
  localparam int ROW_IDX_W   = 6;
  localparam int COL_IDX_W   = 6;
  localparam int STATUS_W    = 2;
  localparam int ROWS_W      = 7;
  localparam int CFG_W       = 8;
  localparam int WIN_W       = 3 * BYTE_W;

  // Counter widths
  localparam int BYTE_CNT_W  = $clog2(ROW_BYTES);
  localparam int ROW_CNT_W   = $clog2(MAX_ROWS + 1);

  localparam logic [CFG_W-1:0] ROW_COUNT_RST = CFG_W'(64);

  // Row marker 00 00 0A 5x
  localparam logic [WIN_W-1:0]  MARK_HEAD     = 24'h00000A;
  localparam logic [BYTE_W-1:0] MARK_NIB_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] MARK_NIB      = 8'h50;
  localparam logic [1:0]        WIN_FULL      = 2'd3;

  // Output packing, lowest bit first
  localparam int OUT_VAL_LO    = 0;
  localparam int OUT_ROW_LO    = OUT_VAL_LO + SAMPLE_W;
  localparam int OUT_COL_LO    = OUT_ROW_LO + ROW_IDX_W;
  localparam int OUT_STAT_LO   = OUT_COL_LO + COL_IDX_W;
  localparam int OUT_ROWS_LO   = OUT_STAT_LO + STATUS_W;
  localparam int OUT_USED_W    = OUT_ROWS_LO + ROWS_W;
  localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_BAD_COUNT  = 2'd2
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] raw_byte;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    logic                 sample_valid;
    logic [SAMPLE_W-1:0]  sample_value;
    logic [ROW_IDX_W-1:0] row_index;
    logic [COL_IDX_W-1:0] column_index;
    logic                 frame_done;
    status_t              frame_status;
    logic [ROWS_W-1:0]    rows_found;
  } result_t;

endpackage

@@ design/mrdb_in_stage.sv @@
module mrdb_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  input  logic              advance,
  output logic              item_valid,
  output mrdb_pkg::in_item_t item
);
  import mrdb_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.raw_byte <= in_tdata[BYTE_W-1:0];
      item_r.is_last  <= in_tlast;
    end
  end

endmodule

@@ design/mrdb_core.sv @@
module mrdb_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [mrdb_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                     fire,
  input  mrdb_pkg::in_item_t       item,
  output logic                     res_valid,
  output mrdb_pkg::result_t        res
);
  import mrdb_pkg::*;

  logic [CFG_W-1:0]      exp_rows_r;
  logic [WIN_W-1:0]      recent_r,     recent_nxt;
  logic [1:0]            fill_r,       fill_nxt;
  logic                  collect_r,    collect_nxt;
  logic [BYTE_CNT_W-1:0] byte_cnt_r,   byte_cnt_nxt;
  logic [BYTE_W-1:0]     held_r,       held_nxt;
  logic [ROW_CNT_W-1:0]  row_cnt_r,    row_cnt_nxt;

  logic valid_cfg;
  logic active;
  logic have_sample;
  logic marker_hit;

  always_comb begin
    valid_cfg  = (exp_rows_r != '0) && (exp_rows_r <= CFG_W'(MAX_ROWS));
    active     = valid_cfg && (CFG_W'(row_cnt_r) < exp_rows_r);
    marker_hit = (fill_r == WIN_FULL) && (recent_r == MARK_HEAD) &&
                 ((item.raw_byte & MARK_NIB_MASK) == MARK_NIB);

    recent_nxt   = recent_r;
    fill_nxt     = fill_r;
    collect_nxt  = collect_r;
    byte_cnt_nxt = byte_cnt_r;
    held_nxt     = held_r;
    row_cnt_nxt  = row_cnt_r;
    have_sample  = 1'b0;
    res          = '0;

    if (active) begin
      if (!collect_r) begin
        if (marker_hit) begin
          collect_nxt  = 1'b1;
          byte_cnt_nxt = '0;
          fill_nxt     = '0;
          recent_nxt   = '0;
        end else begin
          recent_nxt = {recent_r[WIN_W-BYTE_W-1:0], item.raw_byte};
          if (fill_r != WIN_FULL) begin
            fill_nxt = fill_r + 2'd1;
          end
        end
      end else begin
        if (!byte_cnt_r[0]) begin
          held_nxt = item.raw_byte;
        end else begin
          have_sample         = 1'b1;
          res.sample_value    = {held_r, item.raw_byte};
          res.row_index       = ROW_IDX_W'(row_cnt_r);
          res.column_index    = COL_IDX_W'(byte_cnt_r >> 1);
        end
        if (byte_cnt_r == BYTE_CNT_W'(ROW_BYTES - 1)) begin
          row_cnt_nxt  = row_cnt_r + ROW_CNT_W'(1);
          collect_nxt  = 1'b0;
          byte_cnt_nxt = '0;
          fill_nxt     = '0;
          recent_nxt   = '0;
        end else begin
          byte_cnt_nxt = byte_cnt_r + BYTE_CNT_W'(1);
        end
      end
    end

    res.sample_valid = have_sample;
    res.frame_done   = item.is_last;
    res.rows_found   = valid_cfg ? ROWS_W'(row_cnt_nxt) : '0;
    if (item.is_last) begin
      if (!valid_cfg) begin
        res.frame_status = ST_BAD_COUNT;
      end else if (CFG_W'(row_cnt_nxt) == exp_rows_r) begin
        res.frame_status = ST_OK;
      end else begin
        res.frame_status = ST_INCOMPLETE;
      end
      // end of transfer: drop all frame state
      recent_nxt   = '0;
      fill_nxt     = '0;
      collect_nxt  = 1'b0;
      byte_cnt_nxt = '0;
      held_nxt     = '0;
      row_cnt_nxt  = '0;
    end

    res_valid = have_sample || item.is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_rows_r <= ROW_COUNT_RST;
      recent_r   <= '0;
      fill_r     <= '0;
      collect_r  <= 1'b0;
      byte_cnt_r <= '0;
      held_r     <= '0;
      row_cnt_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        exp_rows_r <= cfg_wr_data;
      end
      if (fire) begin
        recent_r   <= recent_nxt;
        fill_r     <= fill_nxt;
        collect_r  <= collect_nxt;
        byte_cnt_r <= byte_cnt_nxt;
        held_r     <= held_nxt;
        row_cnt_r  <= row_cnt_nxt;
      end
    end
  end

endmodule

@@ design/mrdb_out_stage.sv @@
module mrdb_out_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  mrdb_pkg::result_t               res,
  output logic                            load_ok,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mrdb_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tuser,
  output logic                            out_tlast
);
  import mrdb_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign load_ok    = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.sample_valid;
  assign out_tlast  = res_r.frame_done;
  assign out_tdata  = OUT_DATA_W'({res_r.rows_found, res_r.frame_status, res_r.column_index,
                                   res_r.row_index, res_r.sample_value});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ok) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && load) begin
      res_r <= res;
    end
  end

endmodule

@@ design/marker_row_deframer_byteswap.sv @@
// Row deframer with byte swap. Raw sensor bytes enter one per transaction on
// the in_ stream (tlast marks the final byte of a transfer). Between rows the
// block hunts for the marker 00 00 0A 5x; after it, 2*ROW_SAMPLES bytes are
// paired big-endian into 16-bit samples, each sent out with its row and
// column. Once cfg_wr_data rows (register reset 64, valid 1..MAX_ROWS) are
// gathered, bytes are dropped until tlast. The transaction for the last byte
// carries tlast and a status: 0 complete, 1 incomplete (discard the frame),
// 2 invalid row count. Bytes that complete no sample and are not last yield
// no output transaction. The block takes one byte per clock while the output
// is not stalled: a byte sits in the input register while the window compare
// and counter update run, then its result lands in the output register; both
// registers advance whenever the output register is empty or being taken, so
// throughput is one transaction per cycle. Write the row count register only
// while no transaction is in flight, with both the input and the output
// register empty.
module marker_row_deframer_byteswap (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [mrdb_pkg::CFG_W-1:0]      cfg_wr_data,  // expected_row_count
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,     // raw_byte
  input  logic                            in_tlast,     // is_last
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // sample_value[15:0], row_index[21:16], column_index[27:22],
  // frame_status[29:28], rows_found[36:30], zero fill
  output logic [mrdb_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tuser,    // sample_valid
  output logic                            out_tlast     // frame_done
);
  import mrdb_pkg::*;

  logic     item_valid;
  in_item_t item;
  logic     load_ok;
  logic     fire;
  logic     res_valid;
  result_t  res;

  // advance the input register only when the output side can take a result
  assign fire = item_valid && load_ok;

  mrdb_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .advance    (load_ok),
    .item_valid (item_valid),
    .item       (item)
  );

  mrdb_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .item        (item),
    .res_valid   (res_valid),
    .res         (res)
  );

  mrdb_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire && res_valid),
    .res        (res),
    .load_ok    (load_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ design/mrdb_checker.sv @@
module mrdb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mrdb_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);
  import mrdb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  a_has_content: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser || out_tlast)
    else $error("output transaction with neither sample nor frame end");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[OUT_ROWS_LO-1:OUT_STAT_LO] == ST_OK)
    else $error("frame status set before frame end");

  a_no_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[OUT_ROW_LO-1:OUT_VAL_LO] == '0)
    else $error("sample value nonzero without a sample");

  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_USED_W-1:OUT_ROWS_LO] <= ROWS_W'(MAX_ROWS))
    else $error("rows found beyond the row limit");

endmodule

bind marker_row_deframer_byteswap mrdb_checker u_mrdb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
